FILE: hw/rtl/ovle_pkg.sv
// Shared types and constants for the ordered value list engine.
// No dependencies.
package ovle_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned VALUE_W       = 32;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_DELETE   = 2'd1,
    CMD_SEARCH   = 2'd2,
    CMD_TRAVERSE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_t;

endpackage

FILE: hw/rtl/ordered_value_list_engine.sv
// Ordered value list engine: bounded list held compacted in one synchronous memory.
// Depends on ovle_pkg.
//
// Insert: appends the value at the list end. Search/delete: scan one entry per cycle
// through the memory read port until a match or the list end; delete then moves each
// later entry up one slot per cycle. Traverse: one result beat per cycle while the
// output is taken. One item at a time.
// Reset (rst, synchronous) empties the list and clears control; store data is kept.
module ordered_value_list_engine #(
  parameter int unsigned DEPTH = ovle_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic signed [ovle_pkg::VALUE_W-1:0] s_axis_tdata,  // [31:0] operand_value
  input  logic        [1:0]                 s_axis_tuser,  // [1:0] command
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic signed [ovle_pkg::VALUE_W-1:0] m_axis_tdata,  // [31:0] entry_value
  output logic        [2:0]                 m_axis_tuser,  // [1:0] status, [2] found
  output logic                              m_axis_tlast
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned VW = ovle_pkg::VALUE_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_TRAV  = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] idx, idx_next;
  logic [CW-1:0] idx_ext;

  logic signed [VW-1:0] mem [DEPTH];
  logic signed [VW-1:0] rd_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic signed [VW-1:0] wr_data;

  logic signed [VW-1:0] opnd;
  logic                 is_del;
  ovle_pkg::status_t    resp_status, resp_status_next;
  logic                 resp_found, resp_found_next;

  logic                 out_valid;
  logic                 out_free;
  logic                 ld;
  ovle_pkg::status_t    ld_status;
  logic                 ld_found;
  logic signed [VW-1:0] ld_value;
  logic                 ld_last;
  ovle_pkg::status_t    out_status;
  logic                 out_found;
  logic signed [VW-1:0] out_value;
  logic                 out_last;

  ovle_pkg::cmd_t cmd_in;
  logic           accept;

  assign cmd_in        = ovle_pkg::cmd_t'(s_axis_tuser);
  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign idx_ext       = CW'(idx);
  assign out_free      = !out_valid || m_axis_tready;

  always_comb begin
    state_next       = state;
    idx_next         = idx;
    count_next       = count;
    rd_en            = 1'b0;
    rd_addr          = idx;
    wr_en            = 1'b0;
    wr_addr          = idx;
    wr_data          = rd_data;
    resp_status_next = resp_status;
    resp_found_next  = resp_found;
    ld               = 1'b0;
    ld_status        = resp_status;
    ld_found         = resp_found;
    ld_value         = '0;
    ld_last          = 1'b1;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          case (cmd_in)
            ovle_pkg::CMD_INSERT: begin
              resp_found_next = 1'b0;
              if (count == CW'(DEPTH)) begin
                resp_status_next = ovle_pkg::STAT_FULL;
              end else begin
                wr_en            = 1'b1;
                wr_addr          = count[AW-1:0];
                wr_data          = s_axis_tdata;
                count_next       = count + CW'(1);
                resp_status_next = ovle_pkg::STAT_OK;
              end
              state_next = S_RESP;
            end
            ovle_pkg::CMD_DELETE, ovle_pkg::CMD_SEARCH: begin
              if (count == '0) begin
                resp_status_next = ovle_pkg::STAT_NOTFOUND;
                resp_found_next  = 1'b0;
                state_next       = S_RESP;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                idx_next   = '0;
                state_next = S_SCAN;
              end
            end
            default: begin
              if (count == '0) begin
                resp_status_next = ovle_pkg::STAT_EMPTY;
                resp_found_next  = 1'b0;
                state_next       = S_RESP;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                idx_next   = '0;
                state_next = S_TRAV;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rd_data == opnd) begin
          resp_status_next = ovle_pkg::STAT_OK;
          resp_found_next  = 1'b1;
          if (!is_del) begin
            state_next = S_RESP;
          end else if (idx_ext + CW'(1) == count) begin
            count_next = count - CW'(1);
            state_next = S_RESP;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = idx + AW'(1);
            state_next = S_SHIFT;
          end
        end else if (idx_ext + CW'(1) == count) begin
          resp_status_next = ovle_pkg::STAT_NOTFOUND;
          resp_found_next  = 1'b0;
          state_next       = S_RESP;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = idx + AW'(1);
          idx_next = idx + AW'(1);
        end
      end
      S_SHIFT: begin
        // rd_data holds entry idx+1; move it down into idx
        wr_en    = 1'b1;
        wr_addr  = idx;
        wr_data  = rd_data;
        idx_next = idx + AW'(1);
        if (idx_ext + CW'(2) == count) begin
          count_next = count - CW'(1);
          state_next = S_RESP;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx + AW'(2);
        end
      end
      S_TRAV: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_status = ovle_pkg::STAT_OK;
          ld_found  = 1'b0;
          ld_value  = rd_data;
          ld_last   = (idx_ext + CW'(1) == count);
          if (idx_ext + CW'(1) == count) begin
            state_next = S_IDLE;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = idx + AW'(1);
            idx_next = idx + AW'(1);
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          ld         = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (ld) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx         <= idx_next;
    resp_status <= resp_status_next;
    resp_found  <= resp_found_next;
    if (accept) begin
      opnd   <= s_axis_tdata;
      is_del <= (cmd_in == ovle_pkg::CMD_DELETE);
    end
    if (ld) begin
      out_status <= ld_status;
      out_found  <= ld_found;
      out_value  <= ld_value;
      out_last   <= ld_last;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_value;
  assign m_axis_tuser  = {out_found, out_status};
  assign m_axis_tlast  = out_last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |-> idx_ext + CW'(2) <= count)
    else $error("shift beyond list end");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    accept && cmd_in == ovle_pkg::CMD_INSERT && count != CW'(DEPTH)
    |=> count == $past(count) + CW'(1))
    else $error("insert did not grow list");

  a_trav_end: assert property (@(posedge clk) disable iff (rst)
    state == S_TRAV && out_free && idx_ext + CW'(1) == count |=> state == S_IDLE)
    else $error("traverse did not finish on last entry");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_axis_tready |=> !($past(ld)) || out_valid)
    else $error("pending result lost");

endmodule
